### hdl/assert_macros.svh
// assertion helpers for the polygon edge pick checker
// depends on nothing; included by the checker file only
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### hdl/pep_pkg.sv
// shared constants, widths, codes and types of the polygon edge pick unit
// no dependencies; imported by all files but pep_ram and assert_macros.svh
`timescale 1ns / 1ps

package pep_pkg;

  // geometry limits
  localparam int MAX_VERTICES = 8;
  localparam int COORD_BITS   = 16;

  // field widths
  localparam int MODE_W     = 1;
  localparam int SLOT_W     = 3;
  localparam int VCOUNT_W   = 4;
  localparam int DIST_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // vertex store
  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int VTX_W = 2 * COORD_BITS;

  // datapath widths
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int L2_W    = 2 * COORD_BITS + 2;
  localparam int DOT_W   = 2 * COORD_BITS + 3;
  localparam int OVER_W  = DOT_W + 1;
  localparam int D2_W    = 2 * DIST_W;
  // magnitudes at or above 2^CAP_W can never pass the distance test
  localparam int CAP_W   = (D2_W + L2_W) / 2;
  localparam int SQ_W    = 2 * CAP_W;
  localparam int CMP_W   = SQ_W + L2_W;
  localparam int MUL_A_W = CAP_W + 1;
  localparam int MUL_B_W = L2_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // item modes
  localparam logic [MODE_W-1:0] MODE_WRITE = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_QUERY = MODE_W'(1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SEL_DIST     = CFG_IDX_W'(1);

  // configuration reset values
  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = VCOUNT_W'(4);
  localparam logic [DIST_W-1:0]   DIST_RESET   = DIST_W'(8);

  // query handed to the sequencer
  typedef struct packed {
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic [CNT_W-1:0]             n;
    logic [DIST_W-1:0]            d;
  } pep_query_t;

  // answer of one query
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] pick;
  } pep_result_t;

  // sequencer status toward the top level
  typedef struct packed {
    logic idle;
    logic done;
  } pep_seq_status_t;

endpackage

### hdl/pep_if.sv
// valid/ready channel interfaces: input items, results and config writes
// depends on pep_pkg
`timescale 1ns / 1ps

interface pep_in_if import pep_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [MODE_W-1:0]            mode;
  logic [SLOT_W-1:0]            vertex_slot;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;

  modport source (output valid, mode, vertex_slot, coord_x, coord_y, input ready);
  modport sink   (input valid, mode, vertex_slot, coord_x, coord_y, output ready);
endinterface

interface pep_res_if import pep_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              hit;
  logic [SLOT_W-1:0] picked_vertex;

  modport source (output valid, hit, picked_vertex, input ready);
  modport sink   (input valid, hit, picked_vertex, output ready);
endinterface

interface pep_cfg_if import pep_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/polygon_edge_pick_unit.sv
// polygon edge pick unit top level: config registers, vertex RAM, result register
// vertex write: leaves the unit ready for the next item; query over n edges:
//   each edge runs the per-edge product sequence on the one shared multiplier;
//   early edge rejects shorten it
// one item at a time; reset clears config to 4 vertices and distance 8, vertex RAM undefined
// depends on pep_pkg, pep_if, pep_ram, pep_mul, pep_seq
`timescale 1ns / 1ps

module polygon_edge_pick_unit import pep_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  pep_in_if.sink        in_i,
  pep_cfg_if.sink       cfg_i,
  pep_res_if.source     res_o
);

  logic [VCOUNT_W-1:0] vertex_count_q;
  logic [DIST_W-1:0]   sel_dist_q;

  logic                res_valid_q;
  logic                res_hit_q;
  logic [IDX_W-1:0]    res_pick_q;

  logic                in_xfer;
  logic                vtx_we;
  logic                start;
  logic                done_ready;
  logic [CNT_W-1:0]    n_sat;
  pep_query_t          query;
  pep_seq_status_t     seq_status;
  pep_result_t         seq_result;

  logic [IDX_W-1:0]          rd_addr;
  logic [VTX_W-1:0]          rd_data;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;

  // configuration writes, always accepted
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= VCOUNT_RESET;
      sel_dist_q     <= DIST_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_VERTEX_COUNT: vertex_count_q <= VCOUNT_W'(cfg_i.data);
        CFG_SEL_DIST:     sel_dist_q     <= DIST_W'(cfg_i.data);
        default: begin
        end
      endcase
    end
  end

  // input transfer decode
  assign in_i.ready = seq_status.idle;
  assign in_xfer    = in_i.valid && in_i.ready;
  assign vtx_we     = in_xfer && (in_i.mode == MODE_WRITE) &&
                      (int'(in_i.vertex_slot) < MAX_VERTICES);
  assign start      = in_xfer && (in_i.mode == MODE_QUERY);

  // vertex count clipped to the store depth
  assign n_sat = (int'(vertex_count_q) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES)
                                                      : CNT_W'(vertex_count_q);

  assign query.px = in_i.coord_x;
  assign query.py = in_i.coord_y;
  assign query.n  = n_sat;
  assign query.d  = sel_dist_q;

  // vertex store, x in the upper half
  pep_ram #(
    .WIDTH (VTX_W),
    .DEPTH (MAX_VERTICES)
  ) u_vtx_ram (
    .clk_i   (clk_i),
    .we_i    (vtx_we),
    .waddr_i (IDX_W'(in_i.vertex_slot)),
    .wdata_i ({in_i.coord_x, in_i.coord_y}),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  pep_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  pep_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .query_i      (query),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .mul_a_o      (mul_a),
    .mul_b_o      (mul_b),
    .mul_p_i      (mul_p),
    .done_ready_i (done_ready),
    .status_o     (seq_status),
    .result_o     (seq_result)
  );

  // result register between sequencer and output channel
  assign done_ready = !res_valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (seq_status.done && done_ready) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_status.done && done_ready) begin
      res_hit_q  <= seq_result.hit;
      res_pick_q <= seq_result.hit ? seq_result.pick : '0;
    end
  end

  assign res_o.valid         = res_valid_q;
  assign res_o.hit           = res_hit_q;
  assign res_o.picked_vertex = SLOT_W'(res_pick_q);

endmodule

### hdl/pep_ram.sv
// generic single-write, single-read RAM with registered read data
// no dependencies
`timescale 1ns / 1ps

module pep_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/pep_mul.sv
// shared signed multiplier with a registered product
// depends on pep_pkg
`timescale 1ns / 1ps

module pep_mul import pep_pkg::*; (
  input  logic                      clk_i,
  input  logic signed [MUL_A_W-1:0] a_i,
  input  logic signed [MUL_B_W-1:0] b_i,
  output logic signed [PROD_W-1:0]  p_o
);

  logic signed [PROD_W-1:0] p_q;

  // one product per cycle
  always_ff @(posedge clk_i) begin
    p_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign p_o = p_q;

endmodule

### hdl/pep_seq.sv
// edge walk sequencer: fetches vertices, steps the shared multiplier per edge
// depends on pep_pkg; drives pep_mul operands and the vertex RAM read address
`timescale 1ns / 1ps

module pep_seq import pep_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  pep_query_t                query_i,
  output logic [IDX_W-1:0]          rd_addr_o,
  input  logic [VTX_W-1:0]          rd_data_i,
  output logic signed [MUL_A_W-1:0] mul_a_o,
  output logic signed [MUL_B_W-1:0] mul_b_o,
  input  logic signed [PROD_W-1:0]  mul_p_i,
  input  logic                      done_ready_i,
  output pep_seq_status_t           status_o,
  output pep_result_t               result_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_FETCH_S, S_LOAD_T,
    S_M_DXDX, S_M_DYDY, S_M_QXDX, S_M_QYDY, S_M_DXQY, S_M_DYQX,
    S_M_LIM, S_M_EE, S_M_CC,
    S_M_LHS_LO, S_M_LHS_HI, S_M_RHS_LO, S_M_RHS_HI, S_ACC_RHS,
    S_DECIDE, S_NEXT, S_DONE
  } state_e;

  state_e state_q, state_d;

  // query context
  logic signed [COORD_BITS-1:0] px_q, py_q;
  logic [CNT_W-1:0]             n_q;
  logic [D2_W-1:0]              d2_q;

  // edge walk
  logic [CNT_W-1:0]             t_q;
  logic [IDX_W-1:0]             s_idx_q;
  logic signed [COORD_BITS-1:0] sx_q, sy_q, tx_q, ty_q;
  logic signed [DIFF_W-1:0]     dx_q, dy_q, qx_q, qy_q;

  // per-edge arithmetic
  logic [L2_W-1:0]              l2_q;
  logic signed [DOT_W-1:0]      dot_q, cross_q;
  logic [CAP_W-1:0]             e_q, c_q;
  logic                         e_far_q;
  logic [SQ_W-1:0]              lim_q, c2_q;
  logic [CMP_W-1:0]             lhs_q, rhs_q;
  logic [IDX_W-1:0]             pick_cand_q;

  // best edge so far, distance held as sqrt(bc2 / bl)
  logic [SQ_W-1:0]              bc2_q;
  logic [L2_W-1:0]              bl_q;
  logic                         hit_q;
  logic [IDX_W-1:0]             pick_q;

  // combinational helpers
  logic signed [COORD_BITS-1:0] rd_x, rd_y;
  logic [L2_W-1:0]              p_l2;
  logic signed [DOT_W-1:0]      p_dot;
  logic [SQ_W-1:0]              p_sq;
  logic [CMP_W-1:0]             p_wide;
  logic signed [OVER_W-1:0]     dot_ext, l2_ext, over, two_dot;
  logic [OVER_W-1:0]            e_full;
  logic [DOT_W-1:0]             cmag;
  logic                         c_far;
  logic                         pick_ge;
  logic [CNT_W-1:0]             n_m1, qn_m1, t_p1;

  assign rd_x = rd_data_i[VTX_W-1:COORD_BITS];
  assign rd_y = rd_data_i[COORD_BITS-1:0];

  assign p_l2   = mul_p_i[L2_W-1:0];
  assign p_dot  = mul_p_i[DOT_W-1:0];
  assign p_sq   = mul_p_i[SQ_W-1:0];
  assign p_wide = CMP_W'($unsigned(mul_p_i));

  // projection overshoot beyond either end of the edge
  assign dot_ext = OVER_W'(dot_q);
  assign l2_ext  = $signed(OVER_W'(l2_q));
  assign over    = dot_ext - l2_ext;
  assign two_dot = $signed({dot_q, 1'b0});
  assign pick_ge = (two_dot >= l2_ext);

  always_comb begin
    if (dot_ext[OVER_W-1]) begin
      e_full = $unsigned(-dot_ext);
    end else if (!over[OVER_W-1] && (over != '0)) begin
      e_full = $unsigned(over);
    end else begin
      e_full = '0;
    end
  end

  // perpendicular magnitude and its early reject
  assign cmag  = cross_q[DOT_W-1] ? $unsigned(-cross_q) : $unsigned(cross_q);
  assign c_far = |cmag[DOT_W-1:CAP_W];

  assign n_m1  = n_q - 1'b1;
  assign qn_m1 = query_i.n - 1'b1;
  assign t_p1  = t_q + 1'b1;

  // vertex read address, data arrives in the next cycle
  always_comb begin
    case (state_q)
      S_IDLE:    rd_addr_o = qn_m1[IDX_W-1:0];
      S_FETCH_S: rd_addr_o = '0;
      S_NEXT:    rd_addr_o = t_p1[IDX_W-1:0];
      default:   rd_addr_o = t_q[IDX_W-1:0];
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    case (state_q)
      S_IDLE: begin
        mul_a_o = $signed(MUL_A_W'(query_i.d));
        mul_b_o = $signed(MUL_B_W'(query_i.d));
      end
      S_M_DXDX: begin
        mul_a_o = MUL_A_W'(dx_q);
        mul_b_o = MUL_B_W'(dx_q);
      end
      S_M_DYDY: begin
        mul_a_o = MUL_A_W'(dy_q);
        mul_b_o = MUL_B_W'(dy_q);
      end
      S_M_QXDX: begin
        mul_a_o = MUL_A_W'(qx_q);
        mul_b_o = MUL_B_W'(dx_q);
      end
      S_M_QYDY: begin
        mul_a_o = MUL_A_W'(qy_q);
        mul_b_o = MUL_B_W'(dy_q);
      end
      S_M_DXQY: begin
        mul_a_o = MUL_A_W'(dx_q);
        mul_b_o = MUL_B_W'(qy_q);
      end
      S_M_DYQX: begin
        mul_a_o = MUL_A_W'(dy_q);
        mul_b_o = MUL_B_W'(qx_q);
      end
      S_M_LIM: begin
        mul_a_o = $signed(MUL_A_W'(d2_q));
        mul_b_o = $signed(MUL_B_W'(l2_q));
      end
      S_M_EE: begin
        mul_a_o = $signed(MUL_A_W'(e_q));
        mul_b_o = $signed(MUL_B_W'(e_q));
      end
      S_M_CC: begin
        mul_a_o = $signed(MUL_A_W'(c_q));
        mul_b_o = $signed(MUL_B_W'(c_q));
      end
      S_M_LHS_LO: begin
        mul_a_o = $signed(MUL_A_W'(p_sq[CAP_W-1:0]));
        mul_b_o = $signed(MUL_B_W'(bl_q));
      end
      S_M_LHS_HI: begin
        mul_a_o = $signed(MUL_A_W'(c2_q[SQ_W-1:CAP_W]));
        mul_b_o = $signed(MUL_B_W'(bl_q));
      end
      S_M_RHS_LO: begin
        mul_a_o = $signed(MUL_A_W'(bc2_q[CAP_W-1:0]));
        mul_b_o = $signed(MUL_B_W'(l2_q));
      end
      S_M_RHS_HI: begin
        mul_a_o = $signed(MUL_A_W'(bc2_q[SQ_W-1:CAP_W]));
        mul_b_o = $signed(MUL_B_W'(l2_q));
      end
      default: begin
        mul_a_o = '0;
        mul_b_o = '0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = (query_i.n == '0) ? S_DONE : S_FETCH_S;
        end
      end
      S_FETCH_S:  state_d = S_LOAD_T;
      S_LOAD_T:   state_d = S_M_DXDX;
      S_M_DXDX:   state_d = S_M_DYDY;
      S_M_DYDY:   state_d = S_M_QXDX;
      S_M_QXDX:   state_d = S_M_QYDY;
      S_M_QYDY:   state_d = (l2_q == '0) ? S_NEXT : S_M_DXQY;
      S_M_DXQY:   state_d = S_M_DYQX;
      S_M_DYQX:   state_d = S_M_LIM;
      S_M_LIM:    state_d = S_M_EE;
      S_M_EE:     state_d = (e_far_q || c_far) ? S_NEXT : S_M_CC;
      S_M_CC:     state_d = (p_sq > lim_q) ? S_NEXT : S_M_LHS_LO;
      S_M_LHS_LO: state_d = S_M_LHS_HI;
      S_M_LHS_HI: state_d = S_M_RHS_LO;
      S_M_RHS_LO: state_d = S_M_RHS_HI;
      S_M_RHS_HI: state_d = S_ACC_RHS;
      S_ACC_RHS:  state_d = S_DECIDE;
      S_DECIDE:   state_d = S_NEXT;
      S_NEXT:     state_d = (t_q == n_m1) ? S_DONE : S_LOAD_T;
      S_DONE: begin
        if (done_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default:    state_d = S_IDLE;
    endcase
  end

  // state and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      hit_q   <= 1'b0;
      pick_q  <= '0;
    end else begin
      state_q <= state_d;
      if ((state_q == S_IDLE) && start_i) begin
        hit_q  <= 1'b0;
        pick_q <= '0;
      end else if ((state_q == S_DECIDE) && (lhs_q <= rhs_q)) begin
        hit_q  <= 1'b1;
        pick_q <= pick_cand_q;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          px_q <= query_i.px;
          py_q <= query_i.py;
          n_q  <= query_i.n;
        end
      end
      S_FETCH_S: begin
        sx_q    <= rd_x;
        sy_q    <= rd_y;
        s_idx_q <= n_m1[IDX_W-1:0];
        t_q     <= '0;
        d2_q    <= mul_p_i[D2_W-1:0];
        bc2_q   <= SQ_W'(mul_p_i[D2_W-1:0]);
        bl_q    <= L2_W'(1);
      end
      S_LOAD_T: begin
        tx_q <= rd_x;
        ty_q <= rd_y;
        dx_q <= DIFF_W'(rd_x) - DIFF_W'(sx_q);
        dy_q <= DIFF_W'(rd_y) - DIFF_W'(sy_q);
        qx_q <= DIFF_W'(px_q) - DIFF_W'(sx_q);
        qy_q <= DIFF_W'(py_q) - DIFF_W'(sy_q);
      end
      S_M_DYDY: l2_q  <= p_l2;
      S_M_QXDX: l2_q  <= l2_q + p_l2;
      S_M_QYDY: dot_q <= p_dot;
      S_M_DXQY: dot_q <= dot_q + p_dot;
      S_M_DYQX: cross_q <= p_dot;
      S_M_LIM: begin
        cross_q     <= cross_q - p_dot;
        e_q         <= e_full[CAP_W-1:0];
        e_far_q     <= |e_full[OVER_W-1:CAP_W];
        pick_cand_q <= pick_ge ? t_q[IDX_W-1:0] : s_idx_q;
      end
      S_M_EE: begin
        lim_q <= p_sq;
        c_q   <= cmag[CAP_W-1:0];
      end
      S_M_LHS_LO: c2_q  <= p_sq;
      S_M_LHS_HI: lhs_q <= p_wide;
      S_M_RHS_LO: lhs_q <= lhs_q + (p_wide << CAP_W);
      S_M_RHS_HI: rhs_q <= p_wide;
      S_ACC_RHS:  rhs_q <= rhs_q + (p_wide << CAP_W);
      S_DECIDE: begin
        if (lhs_q <= rhs_q) begin
          bc2_q <= c2_q;
          bl_q  <= l2_q;
        end
      end
      S_NEXT: begin
        sx_q    <= tx_q;
        sy_q    <= ty_q;
        s_idx_q <= t_q[IDX_W-1:0];
        t_q     <= t_p1;
      end
      default: begin
      end
    endcase
  end

  assign status_o.idle = (state_q == S_IDLE);
  assign status_o.done = (state_q == S_DONE);
  assign result_o.hit  = hit_q;
  assign result_o.pick = pick_q;

endmodule

### hdl/pep_checker.sv
// port-level checks of the polygon edge pick unit, bound to the top level
// depends on pep_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pep_checker import pep_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic [MODE_W-1:0] in_mode_i,
  input logic              res_valid_i,
  input logic              res_ready_i,
  input logic              res_hit_i,
  input logic [SLOT_W-1:0] res_pick_i
);

  // a pending result holds until its transfer
  `ASSERT_NEXT(a_res_hold, clk_i, rst_ni, res_valid_i && !res_ready_i, res_valid_i)

  // no vertex reported without a hit
  `ASSERT_IMPLY(a_miss_pick_zero, clk_i, rst_ni, res_valid_i && !res_hit_i, res_pick_i == '0)

  // a query transfer makes the unit busy
  `ASSERT_NEXT(a_query_busy, clk_i, rst_ni,
               in_valid_i && in_ready_i && (in_mode_i == MODE_QUERY), !in_ready_i)

  // a vertex write leaves the unit ready
  `ASSERT_NEXT(a_write_ready, clk_i, rst_ni,
               in_valid_i && in_ready_i && (in_mode_i == MODE_WRITE), in_ready_i)

  // a new result only follows a busy cycle
  `ASSERT_IMPLY(a_res_after_busy, clk_i, rst_ni, $rose(res_valid_i), !$past(in_ready_i))

endmodule

bind polygon_edge_pick_unit pep_checker u_pep_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_mode_i   (in_i.mode),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_hit_i   (res_o.hit),
  .res_pick_i  (res_o.picked_vertex)
);

### tb/polygon_edge_pick_unit_tb.sv
// self-checking testbench of the polygon edge pick unit: vertex writes, edge pick queries
// and register writes over valid/ready channels, results checked against an in-bench model
// depends on pep_pkg, pep_if and the polygon_edge_pick_unit rtl
`timescale 1ns / 1ps

module polygon_edge_pick_unit_tb;
  import pep_pkg::*;

  // register indexes that the block does not decode
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = CFG_IDX_W'(3);

  localparam int SETTLE_CYCLES = 20;
  localparam int TAIL_CYCLES   = 200;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_ITEMS  = 900;
  localparam int SHOW_LIMIT    = 10;

  typedef logic [127:0] sq_t;

  typedef struct packed {
    logic [MODE_W-1:0]            mode;
    logic [SLOT_W-1:0]            slot;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } pick_item_t;

  logic clk_i;
  logic rst_ni;

  pep_in_if  in_if ();
  pep_cfg_if cfg_if ();
  pep_res_if res_if ();

  polygon_edge_pick_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  // model state: vertex copies and register copies
  longint          vtx_x [MAX_VERTICES];
  longint          vtx_y [MAX_VERTICES];
  logic [VCOUNT_W-1:0] vcount_q = VCOUNT_RESET;
  logic [DIST_W-1:0]   dist_q   = DIST_RESET;

  // stimulus planning copies, updated as items are queued
  int plan_x [MAX_VERTICES];
  int plan_y [MAX_VERTICES];
  int plan_count;
  int plan_dist;

  pick_item_t  pending_items [$];
  pep_result_t pick_expect_q [$];
  pick_item_t  offer;

  logic idle_on;
  logic hold_res;
  int   send_gap;
  int   stall_left;

  int mismatch_count;
  int query_count;
  int write_count;
  int hit_count;
  int result_count;
  int cfg_count;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // nearest edge over the closed loop, exact squared comparisons
  function automatic pep_result_t nearest_edge_pick(input logic signed [COORD_BITS-1:0] qx_in,
                                                    input logic signed [COORD_BITS-1:0] qy_in);
    pep_result_t r;
    longint px, py, dx, dy, qx, qy, l2, dot, over, crs;
    int     n, s;
    sq_t    lim, amt, c, best_c, best_l;
    logic   in_reach;
    r      = '0;
    px     = qx_in;
    py     = qy_in;
    n      = (vcount_q > MAX_VERTICES) ? MAX_VERTICES : int'(vcount_q);
    best_c = sq_t'(dist_q);
    best_l = sq_t'(1);
    s      = n - 1;
    for (int t = 0; t < n; t++) begin
      dx = vtx_x[t] - vtx_x[s];
      dy = vtx_y[t] - vtx_y[s];
      qx = px - vtx_x[s];
      qy = py - vtx_y[s];
      l2 = dx * dx + dy * dy;
      // zero-length edges are skipped
      if (l2 != 0) begin
        dot      = qx * dx + qy * dy;
        over     = dot - l2;
        lim      = sq_t'(dist_q) * sq_t'(dist_q) * sq_t'(l2);
        in_reach = 1'b1;
        if (dot < 0) begin
          amt = sq_t'(-dot);
          if (amt * amt > lim) in_reach = 1'b0;
        end
        if (over > 0) begin
          amt = sq_t'(over);
          if (amt * amt > lim) in_reach = 1'b0;
        end
        if (in_reach) begin
          crs = dx * qy - dy * qx;
          c   = sq_t'((crs < 0) ? -crs : crs);
          // later edges win ties
          if (c * c * best_l <= best_c * best_c * sq_t'(l2)) begin
            best_c = c;
            best_l = sq_t'(l2);
            r.hit  = 1'b1;
            r.pick = (2 * dot >= l2) ? IDX_W'(t) : IDX_W'(s);
          end
        end
      end
      s = t;
    end
    return r;
  endfunction

  function automatic int clamp_coord(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int rand_offset(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic void push_vertex(input int slot, input int x, input int y);
    pick_item_t it;
    it.mode = MODE_WRITE;
    it.slot = SLOT_W'(slot);
    it.x    = COORD_BITS'(clamp_coord(x));
    it.y    = COORD_BITS'(clamp_coord(y));
    plan_x[slot] = clamp_coord(x);
    plan_y[slot] = clamp_coord(y);
    pending_items.push_back(it);
  endfunction

  function automatic void push_query(input int x, input int y);
    pick_item_t it;
    it.mode = MODE_QUERY;
    it.slot = SLOT_W'($urandom_range(0, 7));
    it.x    = COORD_BITS'(clamp_coord(x));
    it.y    = COORD_BITS'(clamp_coord(y));
    pending_items.push_back(it);
  endfunction

  function automatic void flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= SHOW_LIMIT) $display("mismatch at %0t: %s", $realtime, what);
  endfunction

  // register write transfer, model copy follows the accepted write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_VERTEX_COUNT: vcount_q = val[VCOUNT_W-1:0];
      CFG_SEL_DIST:     dist_q   = val[DIST_W-1:0];
      default: ;
    endcase
    cfg_count++;
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] count_data,
                            input logic [CFG_DATA_W-1:0] dist_data);
    write_reg(CFG_VERTEX_COUNT, count_data);
    write_reg(CFG_SEL_DIST, dist_data);
    plan_count = (count_data[VCOUNT_W-1:0] > MAX_VERTICES) ? MAX_VERTICES
                                                            : int'(count_data[VCOUNT_W-1:0]);
    plan_dist  = int'(dist_data);
  endtask

  // wait until every item is taken and every result is back, then let writes finish
  task automatic drain_and_settle();
    while (pending_items.size() != 0 || in_if.valid || pick_expect_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // input driver: offers queued items, predicts on each query transfer and copies each vertex write
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        if (offer.mode == MODE_QUERY) begin
          pick_expect_q.push_back(nearest_edge_pick(offer.x, offer.y));
          query_count++;
        end else begin
          vtx_x[offer.slot] = longint'($signed(offer.x));
          vtx_y[offer.slot] = longint'($signed(offer.y));
          write_count++;
        end
      end
      if (!in_if.valid || in_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_if.valid <= 1'b0;
        end else if (idle_on && pending_items.size() != 0 && $urandom_range(0, 11) == 0) begin
          send_gap = $urandom_range(0, 16);
          in_if.valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          offer = pending_items.pop_front();
          in_if.valid       <= 1'b1;
          in_if.mode        <= offer.mode;
          in_if.vertex_slot <= offer.slot;
          in_if.coord_x     <= offer.x;
          in_if.coord_y     <= offer.y;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: random back-pressure and in-order check
  always @(posedge clk_i) begin
    pep_result_t want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        result_count++;
        if (pick_expect_q.size() == 0) begin
          flag_mismatch($sformatf("result with nothing expected: hit=%0b picked_vertex=%0d",
                                  res_if.hit, res_if.picked_vertex));
        end else begin
          want = pick_expect_q.pop_front();
          if (res_if.hit !== want.hit || res_if.picked_vertex !== want.pick)
            flag_mismatch($sformatf("expected hit=%0b picked_vertex=%0d, got hit=%0b picked_vertex=%0d",
                                    want.hit, want.pick, res_if.hit, res_if.picked_vertex));
          if (want.hit) hit_count++;
        end
      end
      if (hold_res) begin
        res_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 16);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // stimulus sequence
  initial begin : stimulus
    int random_items;
    int round;
    int shape, span, cx, cy, nq, s, t, k, r, ex, ey;
    logic full;
    in_if.valid       = 1'b0;
    in_if.mode        = MODE_WRITE;
    in_if.vertex_slot = '0;
    in_if.coord_x     = '0;
    in_if.coord_y     = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = CFG_VERTEX_COUNT;
    cfg_if.data       = '0;
    res_if.ready      = 1'b0;
    hold_res          = 1'b0;
    idle_on           = 1'b1;
    send_gap          = 0;
    stall_left        = 0;
    mismatch_count    = 0;
    query_count       = 0;
    write_count       = 0;
    hit_count         = 0;
    result_count      = 0;
    cfg_count         = 0;
    random_items      = 0;
    plan_count        = 4;
    plan_dist         = 8;
    rst_ni            = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: 100 by 100 square plus corner extremes in the upper slots
    push_vertex(0, 0, 0);
    push_vertex(1, 100, 0);
    push_vertex(2, 100, 100);
    push_vertex(3, 0, 100);
    push_vertex(4, -32768, -32768);
    push_vertex(5, 32767, 32767);
    push_vertex(6, 32767, -32768);
    push_vertex(7, -32768, 32767);
    push_query(50, 5);
    push_query(50, -8);     // exactly at the threshold
    push_query(50, -9);     // just outside
    push_query(108, 0);     // projection exactly at the reach past the end
    push_query(0, 0);       // adjacent edges tie at a vertex
    push_query(50, 50);
    drain_and_settle();

    // all vertices, widest threshold, decoded and spare registers
    set_config(8'd8, 8'd255);
    write_reg(CFG_SPARE_2, 8'hA5);
    write_reg(CFG_SPARE_3, 8'h5A);
    push_query(-32768, -32768);
    push_query(32767, 32767);
    push_query(0, -32768);
    push_query(32767, 0);
    drain_and_settle();

    // no vertices, then a single vertex
    set_config(8'hF0, 8'd255);
    push_query(0, 0);
    drain_and_settle();
    set_config(8'd1, 8'd255);
    push_query(0, 0);
    drain_and_settle();

    // count above the store size saturates, zero threshold
    set_config(8'd15, 8'd0);
    push_query(50, 0);
    push_query(100, 50);
    drain_and_settle();

    // zero-length edge between slots 0 and 1
    set_config(8'd4, 8'd8);
    push_vertex(1, 0, 0);
    push_query(20, 0);
    drain_and_settle();

    // random polygons with queries mostly near their edges
    round = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (random_items > (RANDOM_ITEMS * 5) / 6) idle_on <= 1'b0;
      if (round == 0 || $urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 7))
          0:       k = $urandom_range(0, 2);
          1:       k = $urandom_range(9, 15);
          default: k = $urandom_range(3, 8);
        endcase
        case ($urandom_range(0, 7))
          0:       r = 0;
          1:       r = 255;
          2:       r = $urandom_range(0, 255);
          default: r = $urandom_range(1, 40);
        endcase
        set_config({4'($urandom_range(0, 15)), 4'(k)}, 8'(r));
      end

      shape = $urandom_range(0, 3);
      case (shape)
        0:       span = 8;
        1:       span = 300;
        2:       span = 6000;
        default: span = 65535;
      endcase
      cx   = (shape == 3) ? 0 : int'($urandom_range(0, 65535)) - 32768;
      cy   = (shape == 3) ? 0 : int'($urandom_range(0, 65535)) - 32768;
      full = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < MAX_VERTICES; i++) begin
        if (full || $urandom_range(0, 1) == 1) begin
          if (i > 0 && $urandom_range(0, 9) == 0) push_vertex(i, plan_x[i-1], plan_y[i-1]);
          else push_vertex(i, cx + rand_offset(span), cy + rand_offset(span));
          random_items++;
        end
      end

      nq = $urandom_range(4, 12);
      for (int j = 0; j < nq; j++) begin
        if ($urandom_range(0, 11) == 0) begin
          // stray vertex rewrite in the middle of the queries
          push_vertex($urandom_range(0, 7), cx + rand_offset(span), cy + rand_offset(span));
        end else if (plan_count >= 2 && $urandom_range(0, 4) != 0) begin
          t  = $urandom_range(0, plan_count - 1);
          s  = (t == 0) ? plan_count - 1 : t - 1;
          ex = plan_x[t] - plan_x[s];
          ey = plan_y[t] - plan_y[s];
          k  = int'($urandom_range(0, 104)) - 20;
          r  = plan_dist + 2;
          push_query(plan_x[s] + (ex * k) / 64 + rand_offset(r),
                     plan_y[s] + (ey * k) / 64 + rand_offset(r));
        end else begin
          push_query(int'($urandom_range(0, 65535)) - 32768,
                     int'($urandom_range(0, 65535)) - 32768);
        end
        random_items++;
      end

      // long receiver hold-off while the sender keeps offering
      if (round == 4) begin
        hold_res <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_res <= 1'b0;
      end
      drain_and_settle();
      round++;
    end

    drain_and_settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("ran %0d queries (%0d hits) and %0d vertex writes over %0d register writes",
             query_count, hit_count, write_count, cfg_count);
    $display("%0d results checked, %0d mismatches", result_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("polygon_edge_pick_unit_tb: clean");
    end else begin
      $display("polygon_edge_pick_unit_tb: errors");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #6_000_000;
    $display("run limit reached with %0d results outstanding", pick_expect_q.size());
    $display("polygon_edge_pick_unit_tb: errors");
    $finish;
  end

endmodule
